// File: rtl/fez_pkg.sv
package fez_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SQUARE_W = 31;
   localparam int ENERGY_W = 41;
   localparam int CROSS_W = 10;
   localparam int FRAME_W = 32;
   localparam int CFG_W = 11;
   localparam int FRAME_LENGTH_RESET = 32;

   typedef struct packed {
      logic [SQUARE_W-1:0] square;
      logic                negative;
   } sq_item_type;

endpackage

// File: rtl/frame_energy_zero_crossing.sv
// Frame energy and zero-crossing counter for a stream of 16-bit audio samples.
// Input channel req_: one signed sample per item. Frames of frame_length
// samples follow back to back; the last sample of each frame produces one
// item on rsp_: frame number, sum of squares (saturating, 41 bits) and the
// count of sign changes inside the frame (zero counts as positive).
// csr_wr_en / csr_wr_data set the frame length; 0 acts as 1 and values above
// MAX_FRAME_LENGTH are clamped. Write it only while the block is idle.
// Throughput is one sample per cycle while results are taken. After the last
// sample of a frame is accepted into the input register, the squaring
// register loads it, then the accumulator loads the result register.
// Synchronous reset clears all sums, the frame number and the valid flags and
// restores a frame length of 32, or MAX_FRAME_LENGTH if that is smaller.
// When rsp_ready is low, samples keep flowing until one that ends a frame
// reaches the accumulator while the result register is still full; the
// pipeline then fills and req_ready drops.
module frame_energy_zero_crossing #(
   parameter int MAX_FRAME_LENGTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [fez_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fez_pkg::FRAME_W-1:0]         rsp_frame_number,
   output logic [fez_pkg::ENERGY_W-1:0]        rsp_energy,
   output logic [fez_pkg::CROSS_W-1:0]         rsp_zero_crossings,
   input  logic                                csr_wr_en,
   input  logic [fez_pkg::CFG_W-1:0]           csr_wr_data
);
   import fez_pkg::*;

   localparam int LEN_W = $clog2(MAX_FRAME_LENGTH) + 1;
   localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
   localparam int LEN_RESET = (FRAME_LENGTH_RESET < MAX_FRAME_LENGTH) ?
                              FRAME_LENGTH_RESET : MAX_FRAME_LENGTH;

   logic [LEN_W-1:0] frame_len_ff, frame_len_in;
   logic [CMP_W-1:0] wr_wide;
   logic             sq_valid, sq_ready;
   sq_item_type      sq_item;

   assign wr_wide = CMP_W'(csr_wr_data);

   always_comb begin
      frame_len_in = frame_len_ff;
      if (csr_wr_en) begin
         if (wr_wide == '0) begin
            frame_len_in = LEN_W'(1);
         end else if (wr_wide > CMP_W'(MAX_FRAME_LENGTH)) begin
            frame_len_in = LEN_W'(MAX_FRAME_LENGTH);
         end else begin
            frame_len_in = wr_wide[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff <= LEN_W'(LEN_RESET);
      end else begin
         frame_len_ff <= frame_len_in;
      end
   end

   fez_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_sample (req_sample),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_item  (sq_item)
   );

   fez_accum #(
      .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH),
      .LEN_W            (LEN_W)
   ) u_accum (
      .clock              (clock),
      .reset              (reset),
      .frame_len          (frame_len_ff),
      .in_valid           (sq_valid),
      .in_ready           (sq_ready),
      .in_item            (sq_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_number   (rsp_frame_number),
      .rsp_energy         (rsp_energy),
      .rsp_zero_crossings (rsp_zero_crossings)
   );

endmodule

// File: rtl/fez_square.sv
module fez_square (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [fez_pkg::SAMPLE_W-1:0] in_sample,
   output logic                          out_valid,
   input  logic                          out_ready,
   output fez_pkg::sq_item_type          out_item
);
   import fez_pkg::*;

   logic                       smp_valid_ff, smp_valid_in;
   logic signed [SAMPLE_W-1:0] smp_ff, smp_in;
   logic                       sq_valid_ff, sq_valid_in;
   sq_item_type                sq_ff, sq_in;
   logic                       sq_load;
   logic signed [2*SAMPLE_W-1:0] product;

   assign sq_load  = !sq_valid_ff || out_ready;
   assign in_ready = !smp_valid_ff || sq_load;
   assign product  = smp_ff * smp_ff;

   always_comb begin
      smp_valid_in = smp_valid_ff;
      smp_in       = smp_ff;
      sq_valid_in  = sq_valid_ff;
      sq_in        = sq_ff;
      if (sq_load) begin
         sq_valid_in     = smp_valid_ff;
         // a square of a 16-bit value never exceeds 2^30
         sq_in.square    = product[SQUARE_W-1:0];
         sq_in.negative  = smp_ff[SAMPLE_W-1];
      end
      if (in_ready) begin
         smp_valid_in = in_valid;
         smp_in       = in_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
      end else begin
         smp_valid_ff <= smp_valid_in;
         sq_valid_ff  <= sq_valid_in;
      end
      smp_ff <= smp_in;
      sq_ff  <= sq_in;
   end

   assign out_valid = sq_valid_ff;
   assign out_item  = sq_ff;

endmodule

// File: rtl/fez_accum.sv
module fez_accum #(
   parameter int MAX_FRAME_LENGTH = 1024,
   parameter int LEN_W = $clog2(MAX_FRAME_LENGTH) + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [LEN_W-1:0]             frame_len,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  fez_pkg::sq_item_type         in_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fez_pkg::FRAME_W-1:0]  rsp_frame_number,
   output logic [fez_pkg::ENERGY_W-1:0] rsp_energy,
   output logic [fez_pkg::CROSS_W-1:0]  rsp_zero_crossings
);
   import fez_pkg::*;

   localparam int CNT_W = LEN_W - 1;

   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [CROSS_W-1:0]  cross_ff, cross_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic                last_neg_ff, last_neg_in;
   logic                have_last_ff, have_last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]  rsp_frame_ff, rsp_frame_in;
   logic [ENERGY_W-1:0] rsp_energy_ff, rsp_energy_in;
   logic [CROSS_W-1:0]  rsp_cross_ff, rsp_cross_in;

   logic [ENERGY_W:0]   energy_sum;
   logic [ENERGY_W-1:0] energy_next;
   logic [CROSS_W-1:0]  cross_next;
   logic [LEN_W-1:0]    count_plus;
   logic                frame_end, out_free, take;

   assign count_plus = {1'b0, count_ff} + LEN_W'(1);
   assign frame_end  = count_plus >= frame_len;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign in_ready   = !frame_end || out_free;
   assign take       = in_valid && in_ready;

   // all-ones is the saturation value, so a carry out means overflow
   assign energy_sum  = {1'b0, energy_ff} + (ENERGY_W + 1)'(in_item.square);
   assign energy_next = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];

   always_comb begin
      cross_next = cross_ff;
      if (have_last_ff && (last_neg_ff != in_item.negative) && (cross_ff != '1)) begin
         cross_next = cross_ff + CROSS_W'(1);
      end
   end

   always_comb begin
      energy_in     = energy_ff;
      cross_in      = cross_ff;
      count_in      = count_ff;
      frame_in      = frame_ff;
      last_neg_in   = last_neg_ff;
      have_last_in  = have_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_frame_in  = rsp_frame_ff;
      rsp_energy_in = rsp_energy_ff;
      rsp_cross_in  = rsp_cross_ff;
      if (take) begin
         if (frame_end) begin
            rsp_valid_in  = 1'b1;
            rsp_frame_in  = frame_ff;
            rsp_energy_in = energy_next;
            rsp_cross_in  = cross_next;
            energy_in     = '0;
            cross_in      = '0;
            count_in      = '0;
            have_last_in  = 1'b0;
            frame_in      = frame_ff + FRAME_W'(1);
         end else begin
            energy_in     = energy_next;
            cross_in      = cross_next;
            count_in      = count_plus[CNT_W-1:0];
            have_last_in  = 1'b1;
         end
         last_neg_in = in_item.negative;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff    <= '0;
         cross_ff     <= '0;
         count_ff     <= '0;
         frame_ff     <= '0;
         last_neg_ff  <= 1'b0;
         have_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         energy_ff    <= energy_in;
         cross_ff     <= cross_in;
         count_ff     <= count_in;
         frame_ff     <= frame_in;
         last_neg_ff  <= last_neg_in;
         have_last_ff <= have_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_frame_ff  <= rsp_frame_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_cross_ff  <= rsp_cross_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_number   = rsp_frame_ff;
   assign rsp_energy         = rsp_energy_ff;
   assign rsp_zero_crossings = rsp_cross_ff;

endmodule

// File: rtl/fez_checker.sv
module fez_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [fez_pkg::FRAME_W-1:0]  rsp_frame_number,
   input logic [fez_pkg::ENERGY_W-1:0] rsp_energy,
   input logic [fez_pkg::CROSS_W-1:0]  rsp_zero_crossings
);
   import fez_pkg::*;

   logic               seen_ff;
   logic [FRAME_W-1:0] last_frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff <= 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
         last_frame_ff <= rsp_frame_number;
      end
   end

   // a stalled result holds its fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_number) &&
      $stable(rsp_energy) && $stable(rsp_zero_crossings))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // frames are numbered one after another
   a_frame_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && seen_ff |->
      rsp_frame_number == FRAME_W'(last_frame_ff + FRAME_W'(1)))
      else $error("frame number skipped");

   // with no result pending nothing can stall the input
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

bind frame_energy_zero_crossing fez_checker u_fez_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_frame_number   (rsp_frame_number),
   .rsp_energy         (rsp_energy),
   .rsp_zero_crossings (rsp_zero_crossings)
);
